@@ design/sre_pkg.sv @@
// shared constants, types and the exponential table for the softmax row engine
package sre_pkg;

    localparam int MAX_ROW_LENGTH  = 64;
    localparam int EXP_TABLE_DEPTH = 1024;
    localparam int STORE_DEPTH     = 64;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int IDX_PROD_W      = 12 + $clog2(EXP_TABLE_DEPTH + 1);
    localparam int ELEM_W          = 16;
    localparam int PROB_W          = 17;
    localparam int LEN_W           = 7;
    localparam int SUM_W           = 23;
    localparam int DIV_STEPS       = 17;
    localparam int ITER_W          = $clog2(DIV_STEPS);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);

    typedef logic [PROB_W-1:0] exp_table_t [EXP_TABLE_DEPTH];

    typedef struct packed {
        logic              load;
        logic              exp_wr;
        logic              div_ld;
        logic              div_step;
        logic              out_load;
        logic [ADDR_W-1:0] col;
    } cmd_t;

    typedef struct packed {
        logic row_done;
        logic col_last;
        logic out_free;
    } status_t;

    // entry i holds exp(-16*i/depth) in q1.16, built from a q32 taylor series
    function automatic exp_table_t build_exp_table();
        exp_table_t tbl;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] e;
        x    = (64'd16 << 32) / EXP_TABLE_DEPTH;
        term = 64'd1 << 32;
        r    = 64'd1 << 32;
        e    = 64'd1 << 32;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * x) >> 32) / 64'(k);
            if (k % 2 == 1)
                r = r - term;
            else
                r = r + term;
        end
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
        begin
            tbl[i] = PROB_W'((e + 64'd32768) >> 16);
            e = (e * r + 64'd2147483648) >> 32;
        end
        return tbl;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

@@ design/sre_datapath.sv @@
// row store, max tracking, exp lookup, sum and serial divider of the softmax engine
module sre_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sre_pkg::cmd_t                 cmd,
    output sre_pkg::status_t              status,
    input  logic                          cfg_we,
    input  logic [sre_pkg::LEN_W-1:0]     cfg_len,
    input  logic signed [sre_pkg::ELEM_W-1:0] element_value,
    input  logic                          last_of_matrix,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [sre_pkg::PROB_W-1:0]    probability,
    output logic [sre_pkg::ADDR_W-1:0]    column_index,
    output logic                          last_of_row,
    output logic                          last_of_matrix_res
);
    import sre_pkg::*;

    logic [PROB_W-1:0]        store_mem [STORE_DEPTH];
    logic [PROB_W-1:0]        rd_data_reg;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [PROB_W-1:0]        mem_wdata;

    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         eff_len;
    logic signed [ELEM_W-1:0] max_reg;
    logic [LEN_W-1:0]         count_reg;
    logic [ADDR_W-1:0]        row_last_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic                     pending_reg;
    logic [ADDR_W-1:0]        pos;
    logic [LEN_W-1:0]         cnt;

    logic signed [ELEM_W:0]   diff;
    logic [ELEM_W-1:0]        delta;
    logic [IDX_PROD_W-1:0]    idx_prod;
    logic [EXP_IDX_W-1:0]     exp_idx;
    logic [PROB_W-1:0]        rom_data_reg;
    logic                     rom_zero_reg;
    logic [PROB_W-1:0]        exp_val;

    logic [SUM_W-1:0]         rem_reg;
    logic [PROB_W-1:0]        dv_reg;
    logic [PROB_W-1:0]        quo_reg;
    logic [SUM_W:0]           trial;
    logic                     trial_ge;
    logic [SUM_W:0]           trial_sub;

    logic                     out_valid_reg;
    logic [PROB_W-1:0]        prob_reg;
    logic [ADDR_W-1:0]        col_out_reg;
    logic                     last_row_reg;
    logic                     last_mat_reg;

    assign eff_len = (len_reg == '0) ? LEN_W'(1)
                   : (len_reg > LEN_W'(MAX_ROW_LENGTH)) ? LEN_W'(MAX_ROW_LENGTH) : len_reg;
    assign pos = count_reg[ADDR_W-1:0];
    assign cnt = LEN_W'(pos) + LEN_W'(1);

    assign status.row_done = (cnt >= eff_len);
    assign status.col_last = (cmd.col == row_last_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    // exp lookup: distance from row max scaled onto the table
    assign diff     = {max_reg[ELEM_W-1], max_reg}
                    - {rd_data_reg[ELEM_W-1], rd_data_reg[ELEM_W-1:0]};
    assign delta    = diff[ELEM_W-1:0];
    assign idx_prod = IDX_PROD_W'(delta[11:0]) * IDX_PROD_W'(EXP_TABLE_DEPTH);
    assign exp_idx  = idx_prod[12 +: EXP_IDX_W];
    assign exp_val  = rom_zero_reg ? '0 : rom_data_reg;

    assign mem_we    = cmd.load || cmd.exp_wr;
    assign mem_waddr = cmd.load ? pos : cmd.col;
    assign mem_wdata = cmd.load ? {1'b0, element_value} : exp_val;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        rd_data_reg  <= store_mem[cmd.col];
        rom_data_reg <= EXP_TABLE[exp_idx];
        rom_zero_reg <= |delta[ELEM_W-1:12];
    end

    // one quotient bit per step, remainder always below the sum
    assign trial     = {rem_reg, dv_reg[PROB_W-1]};
    assign trial_ge  = trial >= {1'b0, sum_reg};
    assign trial_sub = trial - {1'b0, sum_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_ld)
        begin
            rem_reg <= SUM_W'(rd_data_reg[PROB_W-1:1]);
            dv_reg  <= {rd_data_reg[0], {(PROB_W-1){1'b0}}};
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
            dv_reg  <= {dv_reg[PROB_W-2:0], 1'b0};
            quo_reg <= {quo_reg[PROB_W-2:0], trial_ge};
        end
        if (cmd.out_load)
        begin
            prob_reg     <= quo_reg;
            col_out_reg  <= cmd.col;
            last_row_reg <= status.col_last;
            last_mat_reg <= status.col_last && pending_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_RESET;
            max_reg       <= '0;
            count_reg     <= '0;
            row_last_reg  <= '0;
            sum_reg       <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                len_reg <= cfg_len;
            if (cmd.load)
            begin
                if (pos == '0 || element_value > max_reg)
                    max_reg <= element_value;
                if (last_of_matrix)
                    pending_reg <= 1'b1;
                if (status.row_done)
                begin
                    count_reg    <= '0;
                    row_last_reg <= pos;
                    sum_reg      <= '0;
                end
                else
                    count_reg <= cnt;
            end
            if (cmd.exp_wr)
                sum_reg <= sum_reg + SUM_W'(exp_val);
            if (cmd.out_load && status.col_last)
                pending_reg <= 1'b0;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid          = out_valid_reg;
    assign probability        = prob_reg;
    assign column_index       = col_out_reg;
    assign last_of_row        = last_row_reg;
    assign last_of_matrix_res = last_mat_reg;

    a_sum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> sum_reg != '0)
        else $error("division started with a zero sum");

    a_rem_below_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> rem_reg < sum_reg)
        else $error("divider remainder not below the sum");

    a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> prob_reg <= PROB_W'(65536))
        else $error("probability above one");

endmodule

@@ design/sre_controller.sv @@
// sequencing state machine for load, exp pass and divide pass
module sre_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output sre_pkg::cmd_t         cmd,
    input  sre_pkg::status_t      status
);
    import sre_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP_RD,
        ST_EXP_LK,
        ST_EXP_WR,
        ST_DIV_RD,
        ST_DIV_LD,
        ST_DIV_IT,
        ST_DIV_OUT
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   col_reg;
    logic [ITER_W-1:0]   iter_reg;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.col      = col_reg;
        cmd.load     = in_valid && (state_reg == ST_IDLE);
        cmd.exp_wr   = (state_reg == ST_EXP_WR);
        cmd.div_ld   = (state_reg == ST_DIV_LD);
        cmd.div_step = (state_reg == ST_DIV_IT);
        cmd.out_load = (state_reg == ST_DIV_OUT) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            iter_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    col_reg <= '0;
                    if (cmd.load && status.row_done)
                        state_reg <= ST_EXP_RD;
                end
                ST_EXP_RD: state_reg <= ST_EXP_LK;
                ST_EXP_LK: state_reg <= ST_EXP_WR;
                ST_EXP_WR:
                begin
                    if (status.col_last)
                    begin
                        col_reg   <= '0;
                        state_reg <= ST_DIV_RD;
                    end
                    else
                    begin
                        col_reg   <= col_reg + ADDR_W'(1);
                        state_reg <= ST_EXP_RD;
                    end
                end
                ST_DIV_RD: state_reg <= ST_DIV_LD;
                ST_DIV_LD:
                begin
                    iter_reg  <= '0;
                    state_reg <= ST_DIV_IT;
                end
                ST_DIV_IT:
                begin
                    if (iter_reg == ITER_W'(DIV_STEPS - 1))
                        state_reg <= ST_DIV_OUT;
                    else
                        iter_reg <= iter_reg + ITER_W'(1);
                end
                ST_DIV_OUT:
                begin
                    if (status.out_free)
                    begin
                        if (status.col_last)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            col_reg   <= col_reg + ADDR_W'(1);
                            state_reg <= ST_DIV_RD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ design/softmax_row_engine.sv @@
// top level of the row-wise fixed-point softmax engine
// Elements of a row are taken one beat per cycle while the engine is idle; each is
// written to a 64-entry row store and the row maximum is tracked. On the beat that
// ends a row (row_length elements, 0 read as 1 and above 64 read as 64) the engine
// stops taking elements and runs two passes over the store: an exp pass that, per
// column, reads the store, reads the table, then writes back and sums, and a divide
// pass set by a one-bit-per-cycle restoring divider (17 quotient bits). The next row
// is taken only once both passes are done; the divide pass waits while the output
// register is still full. Results leave through an output register, so the first
// element of the next row is taken while the last probability still waits.
// row_length is written through the cfg channel, always ready, and must only change
// while the engine is idle.
module softmax_row_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sre_pkg::LEN_W-1:0]           row_length,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [sre_pkg::ELEM_W-1:0]   element_value,
    input  logic                                last_of_matrix,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sre_pkg::PROB_W-1:0]          probability,
    output logic [sre_pkg::ADDR_W-1:0]          column_index,
    output logic                                last_of_row,
    output logic                                last_of_matrix_res
);
    import sre_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    sre_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    sre_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_we             (cfg_valid),
        .cfg_len            (row_length),
        .element_value      (element_value),
        .last_of_matrix     (last_of_matrix),
        .out_ready          (out_ready),
        .out_valid          (out_valid),
        .probability        (probability),
        .column_index       (column_index),
        .last_of_row        (last_of_row),
        .last_of_matrix_res (last_of_matrix_res)
    );

endmodule

@@ tb/sv/softmax_row_engine_test.sv @@
// testbench for the softmax row engine: random rows checked against a softmax predictor
module softmax_row_engine_test;
    import sre_pkg::*;

    typedef struct {
        logic [PROB_W-1:0] prob;
        logic [ADDR_W-1:0] col;
        logic              row_end;
        logic              mat_end;
    } prob_beat_t;

    class softmax_scoreboard;
        logic [PROB_W-1:0] exp_lut [EXP_TABLE_DEPTH];
        logic [15:0]       elems [STORE_DEPTH];
        int                row_max;
        int                count;
        bit                mat_pending;
        logic [LEN_W-1:0]  len_reg;
        prob_beat_t        pending_probs [$];
        int                errors;

        function new();
            logic [63:0] x;
            logic [63:0] term;
            logic [63:0] r;
            logic [63:0] e;
            x = (64'd16 << 32) / EXP_TABLE_DEPTH;
            term = 64'd1 << 32;
            r = 64'd1 << 32;
            e = 64'd1 << 32;
            for (int k = 1; k <= 12; k++)
            begin
                term = ((term * x) >> 32) / 64'(k);
                if (k % 2 == 1)
                    r = r - term;
                else
                    r = r + term;
            end
            for (int i = 0; i < EXP_TABLE_DEPTH; i++)
            begin
                exp_lut[i] = PROB_W'((e + 64'd32768) >> 16);
                e = (e * r + 64'd2147483648) >> 32;
            end
            row_max = 0;
            count = 0;
            mat_pending = 0;
            len_reg = LEN_RESET;
            errors = 0;
        endfunction

        function void note_element(logic [15:0] v, logic mat_end);
            int n;
            int sv;
            int d;
            logic [31:0] sum;
            logic [31:0] ex [STORE_DEPTH];
            prob_beat_t b;
            n = len_reg;
            if (n == 0)
                n = 1;
            if (n > MAX_ROW_LENGTH)
                n = MAX_ROW_LENGTH;
            sv = $signed(v);
            elems[count] = v;
            if (count == 0 || sv > row_max)
                row_max = sv;
            if (mat_end)
                mat_pending = 1;
            count++;
            if (count < n)
                return;
            sum = 0;
            for (int k = 0; k < count; k++)
            begin
                d = row_max - $signed(elems[k]);
                ex[k] = (d >= 4096) ? 0 : exp_lut[(d * EXP_TABLE_DEPTH) >> 12];
                sum += ex[k];
            end
            sum &= 32'h7FFFFF;
            for (int k = 0; k < count; k++)
            begin
                b.prob = PROB_W'((64'(ex[k]) << 16) / sum);
                b.col = ADDR_W'(k);
                b.row_end = (k + 1 == count);
                b.mat_end = b.row_end && mat_pending;
                pending_probs.push_back(b);
            end
            count = 0;
            mat_pending = 0;
        endfunction

        function void check_result(prob_beat_t got);
            prob_beat_t want;
            if (pending_probs.size() == 0)
            begin
                $error("unexpected result beat, probability %0d", got.prob);
                errors++;
                return;
            end
            want = pending_probs.pop_front();
            if (got.prob !== want.prob)
            begin
                $error("probability expected %0d actual %0d", want.prob, got.prob);
                errors++;
            end
            if (got.col !== want.col)
            begin
                $error("column_index expected %0d actual %0d", want.col, got.col);
                errors++;
            end
            if (got.row_end !== want.row_end)
            begin
                $error("last_of_row expected %0d actual %0d", want.row_end, got.row_end);
                errors++;
            end
            if (got.mat_end !== want.mat_end)
            begin
                $error("last_of_matrix_res expected %0d actual %0d", want.mat_end,
                    got.mat_end);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [LEN_W-1:0] row_length = '0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [ELEM_W-1:0] element_value = '0;
    logic last_of_matrix = 0;
    logic out_valid;
    logic out_ready = 0;
    logic [PROB_W-1:0] probability;
    logic [ADDR_W-1:0] column_index;
    logic last_of_row;
    logic last_of_matrix_res;

    softmax_row_engine uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .row_length(row_length),
        .in_valid(in_valid), .in_ready(in_ready),
        .element_value(element_value), .last_of_matrix(last_of_matrix),
        .out_valid(out_valid), .out_ready(out_ready),
        .probability(probability), .column_index(column_index),
        .last_of_row(last_of_row), .last_of_matrix_res(last_of_matrix_res)
    );

    always #2 clk = ~clk;

    softmax_scoreboard board = new();
    int send_idle_pct = 11;
    int recv_idle_pct = 55;
    bit hold_off = 0;
    int cycles = 0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: sample and set ready at the edge
    always @(posedge clk)
    begin
        prob_beat_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.prob = probability;
                got.col = column_index;
                got.row_end = last_of_row;
                got.mat_end = last_of_matrix_res;
                board.check_result(got);
            end
            out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid stays up after a beat; it drops when the sender idles or a length is written
    task automatic send_element(logic [15:0] v, logic m);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        element_value <= v;
        last_of_matrix <= m;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_element(v, m);
    endtask

    task automatic write_length(logic [LEN_W-1:0] n);
        in_valid <= 0;
        while (board.pending_probs.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        cfg_valid <= 1;
        row_length <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        board.len_reg = n;
    endtask

    task automatic random_rows(int elems);
        int n;
        for (int i = 0; i < elems; i++)
        begin
            n = $urandom_range(9);
            if (n < 5)
                send_element(16'($urandom), ($urandom_range(19) == 0));
            else
                // narrow spread keeps many exp values nonzero
                send_element(16'($signed($urandom_range(2000)) - 1000 + 1000 * (n - 7)),
                    ($urandom_range(19) == 0));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, a row of length one, length zero, matrix end mid-row
        write_length(7'd4);
        send_element(16'h7FFF, 0);
        send_element(16'h8000, 1);
        send_element(16'h0000, 0);
        send_element(16'hFFFF, 0);
        send_element(16'h1000, 0);
        send_element(16'h0000, 0);
        send_element(16'h0FFF, 0);
        send_element(16'h1001, 1);
        write_length(7'd1);
        send_element(16'h8000, 1);
        send_element(16'h5555, 0);
        write_length(7'd0);
        send_element(16'hAAAA, 0);
        write_length(7'd127);
        for (int i = 0; i < 64; i++)
            send_element(16'(i * 37), (i == 63));
        // mid-row change of length
        write_length(7'd8);
        send_element(16'h0100, 0);
        send_element(16'h0200, 0);
        send_element(16'h0300, 0);
        write_length(7'd2);
        send_element(16'h0400, 0);
        write_length(7'd5);
        random_rows(100);
        // long receiver hold-off while input keeps coming
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            random_rows(30);
        join
        write_length(7'd3);
        send_idle_pct = 55;
        recv_idle_pct = 11;
        random_rows(99);
        write_length(7'd64);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_rows(64);
        write_length(7'd6);
        random_rows(30);
        in_valid <= 0;
        while (board.pending_probs.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.pending_probs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ files.f @@
design/sre_pkg.sv
design/sre_datapath.sv
design/sre_controller.sv
design/softmax_row_engine.sv
tb/sv/softmax_row_engine_test.sv
